>>> rtl/rpn_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the postfix stack evaluator
// no dependencies; used by every module under rtl/

package rpn_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned STACK_DEPTH_DEF = 16;
  localparam int unsigned QDEPTH          = 4;
  localparam int unsigned QAW             = $clog2(QDEPTH);

  // operation codes as they arrive on the command port
  typedef enum logic [2:0] {
    OP_PUSH  = 3'd0,
    OP_ADD   = 3'd1,
    OP_SUB   = 3'd2,
    OP_MUL   = 3'd3,
    OP_DIV   = 3'd4,
    OP_PRINT = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2,
    ST_DIVZ  = 2'd3
  } status_e;

  // item class decided by the front end
  typedef enum logic [1:0] {
    K_NOP,
    K_PUSH,
    K_ARITH,
    K_PRINT
  } kind_e;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_e;

  typedef enum logic [1:0] {
    EX_IDLE,
    EX_CALC,
    EX_DIV
  } ex_state_e;

  typedef struct packed {
    logic [2:0]                op;
    logic signed [DATA_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    status_e                   status;
    logic                      printed;
    logic signed [DATA_W-1:0]  result;
  } res_t;

  // one entry of the queue between front and back
  typedef struct packed {
    kind_e              kind;
    alu_e               alu;
    logic [DATA_W-1:0]  value;
  } entry_t;

endpackage

>>> rtl/rpn_queue.sv
`timescale 1ns / 1ps
// small fifo of classified items between front end and execution unit
// depends on rpn_pkg (entry_t, QDEPTH, QAW)

module rpn_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rpn_pkg::entry_t entry_i,
  input  logic           pop_i,
  output rpn_pkg::entry_t entry_o,
  output logic           valid_o,
  output logic           full_o
);

  rpn_pkg::entry_t mem_q [rpn_pkg::QDEPTH];

  logic [rpn_pkg::QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [rpn_pkg::QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [rpn_pkg::QAW:0]   cnt_q, cnt_d;
  logic                    do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == (rpn_pkg::QAW+1)'(rpn_pkg::QDEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == rpn_pkg::QAW'(rpn_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == rpn_pkg::QAW'(rpn_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

>>> rtl/rpn_front.sv
`timescale 1ns / 1ps
// command intake: accepts items and sorts them into push, arithmetic, print or no-op
// depends on rpn_pkg (cmd_t, entry_t, op and class codes)

module rpn_front (
  input  logic            start_i,
  input  rpn_pkg::cmd_t   cmd_i,
  input  logic            q_full_i,
  output logic            busy_o,
  output logic            q_push_o,
  output rpn_pkg::entry_t q_entry_o
);

  assign busy_o   = q_full_i;
  assign q_push_o = start_i && !q_full_i;

  always_comb begin
    q_entry_o.value = cmd_i.value;
    q_entry_o.kind  = rpn_pkg::K_NOP;
    q_entry_o.alu   = rpn_pkg::ALU_ADD;
    case (cmd_i.op)
      rpn_pkg::OP_PUSH:  q_entry_o.kind = rpn_pkg::K_PUSH;
      rpn_pkg::OP_ADD: begin
        q_entry_o.kind = rpn_pkg::K_ARITH;
        q_entry_o.alu  = rpn_pkg::ALU_ADD;
      end
      rpn_pkg::OP_SUB: begin
        q_entry_o.kind = rpn_pkg::K_ARITH;
        q_entry_o.alu  = rpn_pkg::ALU_SUB;
      end
      rpn_pkg::OP_MUL: begin
        q_entry_o.kind = rpn_pkg::K_ARITH;
        q_entry_o.alu  = rpn_pkg::ALU_MUL;
      end
      rpn_pkg::OP_DIV: begin
        q_entry_o.kind = rpn_pkg::K_ARITH;
        q_entry_o.alu  = rpn_pkg::ALU_DIV;
      end
      rpn_pkg::OP_PRINT: q_entry_o.kind = rpn_pkg::K_PRINT;
      default:           q_entry_o.kind = rpn_pkg::K_NOP;
    endcase
  end

endmodule

>>> rtl/rpn_div.sv
`timescale 1ns / 1ps
// bit-serial signed divider, truncating toward zero, one quotient bit per cycle
// depends on rpn_pkg (DATA_W)

module rpn_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rpn_pkg::DATA_W-1:0] num_i,
  input  logic [rpn_pkg::DATA_W-1:0] den_i,
  output logic                       done_o,
  output logic [rpn_pkg::DATA_W-1:0] quot_o
);

  localparam int unsigned W  = rpn_pkg::DATA_W;
  localparam int unsigned CW = $clog2(W);

  logic          run_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  rem_q, quo_q, den_q;
  logic          neg_q;
  logic [W:0]    shifted, diff;
  logic          fits;

  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign fits    = !diff[W];

  assign done_o = done_q;
  assign quot_o = neg_q ? (W'(0) - quo_q) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operand magnitudes are taken on start, sign fixed on the way out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i[W-1] ? (W'(0) - num_i) : num_i;
      den_q <= den_i[W-1] ? (W'(0) - den_i) : den_i;
      neg_q <= num_i[W-1] ^ den_i[W-1];
    end else if (run_q) begin
      rem_q <= fits ? diff[W-1:0] : shifted[W-1:0];
      quo_q <= {quo_q[W-2:0], fits};
    end
  end

endmodule

>>> rtl/rpn_exec.sv
`timescale 1ns / 1ps
// execution unit: operand stack memory, count, alu and result register
// depends on rpn_pkg and rpn_div

module rpn_exec #(
  parameter int unsigned STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  rpn_pkg::entry_t q_entry_i,
  output logic            q_pop_o,
  output logic            done_o,
  output rpn_pkg::res_t   res_o
);

  localparam int unsigned W  = rpn_pkg::DATA_W;
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  rpn_pkg::ex_state_e state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  rpn_pkg::kind_e     kind_q, kind_d;
  rpn_pkg::alu_e      alu_q, alu_d;

  logic [W-1:0] stack_mem [STACK_DEPTH];
  logic [W-1:0] rd_top_q, rd_nxt_q;
  logic [AW-1:0] ra_top, ra_nxt, wa;
  logic          we;
  logic [W-1:0]  wd;

  logic          emit;
  rpn_pkg::res_t res_n;
  logic          done_q;
  rpn_pkg::res_t res_q;

  logic          div_start, div_done;
  logic [W-1:0]  div_quot;
  logic [W-1:0]  alu_out;
  logic          full, has_two, empty;

  assign full    = (count_q == CW'(STACK_DEPTH));
  assign has_two = (count_q >= CW'(2));
  assign empty   = (count_q == '0);
  assign ra_top  = AW'(count_q - CW'(1));
  assign ra_nxt  = AW'(count_q - CW'(2));

  rpn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (rd_nxt_q),
    .den_i  (rd_top_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    case (alu_q)
      rpn_pkg::ALU_ADD: alu_out = rd_nxt_q + rd_top_q;
      rpn_pkg::ALU_SUB: alu_out = rd_nxt_q - rd_top_q;
      rpn_pkg::ALU_MUL: alu_out = rd_nxt_q * rd_top_q;
      default:          alu_out = '0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rpn_pkg::EX_IDLE: begin
        if (q_valid_i &&
            ((q_entry_i.kind == rpn_pkg::K_ARITH && has_two) ||
             (q_entry_i.kind == rpn_pkg::K_PRINT && !empty))) begin
          state_d = rpn_pkg::EX_CALC;
        end
      end
      rpn_pkg::EX_CALC: begin
        if (kind_q == rpn_pkg::K_ARITH && alu_q == rpn_pkg::ALU_DIV && rd_top_q != '0) begin
          state_d = rpn_pkg::EX_DIV;
        end else begin
          state_d = rpn_pkg::EX_IDLE;
        end
      end
      rpn_pkg::EX_DIV: begin
        if (div_done) begin
          state_d = rpn_pkg::EX_IDLE;
        end
      end
      default: state_d = rpn_pkg::EX_IDLE;
    endcase
  end

  // datapath controls and result
  always_comb begin
    q_pop_o   = 1'b0;
    we        = 1'b0;
    wa        = ra_nxt;
    wd        = alu_out;
    count_d   = count_q;
    kind_d    = kind_q;
    alu_d     = alu_q;
    emit      = 1'b0;
    div_start = 1'b0;
    res_n     = '{status: rpn_pkg::ST_OK, printed: 1'b0, result: '0};
    case (state_q)
      rpn_pkg::EX_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          kind_d  = q_entry_i.kind;
          alu_d   = q_entry_i.alu;
          case (q_entry_i.kind)
            rpn_pkg::K_PUSH: begin
              emit = 1'b1;
              if (full) begin
                res_n.status = rpn_pkg::ST_OVER;
              end else begin
                we      = 1'b1;
                wa      = AW'(count_q);
                wd      = q_entry_i.value;
                count_d = count_q + 1'b1;
              end
            end
            rpn_pkg::K_ARITH: begin
              if (!has_two) begin
                emit         = 1'b1;
                res_n.status = rpn_pkg::ST_UNDER;
              end
            end
            rpn_pkg::K_PRINT: begin
              if (empty) begin
                emit         = 1'b1;
                res_n.status = rpn_pkg::ST_UNDER;
              end
            end
            default: emit = 1'b1;
          endcase
        end
      end
      rpn_pkg::EX_CALC: begin
        if (kind_q == rpn_pkg::K_PRINT) begin
          emit          = 1'b1;
          res_n.printed = 1'b1;
          res_n.result  = rd_top_q;
          count_d       = count_q - 1'b1;
        end else if (alu_q == rpn_pkg::ALU_DIV) begin
          if (rd_top_q == '0) begin
            emit         = 1'b1;
            res_n.status = rpn_pkg::ST_DIVZ;
          end else begin
            div_start = 1'b1;
          end
        end else begin
          emit    = 1'b1;
          we      = 1'b1;
          count_d = count_q - 1'b1;
        end
      end
      rpn_pkg::EX_DIV: begin
        if (div_done) begin
          emit    = 1'b1;
          we      = 1'b1;
          wd      = div_quot;
          count_d = count_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rpn_pkg::EX_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    alu_q  <= alu_d;
    res_q  <= res_n;
  end

  // stack memory: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we) begin
      stack_mem[wa] <= wd;
    end
    rd_top_q <= stack_mem[ra_top];
    rd_nxt_q <= stack_mem[ra_nxt];
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> rtl/rpn_stack_calculator.sv
`timescale 1ns / 1ps
// top level of the postfix integer evaluator
// depends on rpn_pkg, rpn_front, rpn_queue, rpn_exec (with rpn_div)

// Postfix evaluator: each item on cmd_i (taken when start_i is high and busy_o is low)
// is one operation, and every item yields exactly one result on res_o, marked by a
// one-cycle done_o strobe that the receiver must capture, since it cannot stall the
// block. Items go into a four-entry queue; busy_o is high only while that queue is full.
// After the queue, push, no-op and any underflow or overflow are handled in the idle state
// of the execution unit; add, subtract, multiply and print go through a stack read, then a
// write back; divide also waits on the bit-serial divider, which produces one quotient
// bit per cycle (except when the divisor is zero, since the divider never starts).
// The result strobe is registered and comes in the cycle after the execution unit finishes.
// No clearing pass is needed after reset: the stack starts empty.

module rpn_stack_calculator #(
  parameter int unsigned STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  rpn_pkg::cmd_t cmd_i,
  output logic          busy_o,
  output logic          done_o,
  output rpn_pkg::res_t res_o
);

  // front to queue
  logic            q_push;
  rpn_pkg::entry_t q_in;
  logic            q_full;

  // queue to execution unit
  rpn_pkg::entry_t q_out;
  logic            q_valid;
  logic            q_pop;

  // classify the incoming item
  rpn_front u_front (
    .start_i  (start_i),
    .cmd_i    (cmd_i),
    .q_full_i (q_full),
    .busy_o   (busy_o),
    .q_push_o (q_push),
    .q_entry_o(q_in)
  );

  // decouples intake from a long divide
  rpn_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_in),
    .pop_i  (q_pop),
    .entry_o(q_out),
    .valid_o(q_valid),
    .full_o (q_full)
  );

  // stack, alu, divider and the result register
  rpn_exec #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_exec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_entry_i(q_out),
    .q_pop_o  (q_pop),
    .done_o   (done_o),
    .res_o    (res_o)
  );

  // the front never writes into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !q_push)
    else $error("item written into full queue");

  // a printed value always comes with ok status
  a_print_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.printed) |-> (res_o.status == rpn_pkg::ST_OK))
    else $error("printed result with error status");

  // an empty queue never holds the intake off
  a_busy_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_valid |-> !busy_o)
    else $error("busy while queue empty");

  // a strobe in one cycle means the unit popped or was working the cycle before
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(q_pop || (u_exec.state_q != rpn_pkg::EX_IDLE)))
    else $error("result without a cause");

endmodule

>>> verif/tb_rpn_stack_calculator.sv
`timescale 1ns / 1ps
// self-checking testbench for the postfix stack evaluator: directed, overflow and random tests
// depends on rpn_pkg and rpn_stack_calculator; keeps its own model of the operand stack

module tb_rpn_stack_calculator;

  localparam int unsigned STACK_DEPTH    = rpn_pkg::STACK_DEPTH_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 50;
  // op codes with no operation behind them
  localparam logic [2:0]  OP_SPARE_A     = 3'd6;
  localparam logic [2:0]  OP_SPARE_B     = 3'd7;

  logic          clk_i   = 1'b0;
  logic          rst_ni  = 1'b0;
  logic          start_i = 1'b0;
  rpn_pkg::cmd_t cmd_i   = '0;
  logic          busy_o;
  logic          done_o;
  rpn_pkg::res_t res_o;

  rpn_stack_calculator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_i  (cmd_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the operand stack, advanced once per accepted item
  logic [rpn_pkg::DATA_W-1:0] stack_mem [STACK_DEPTH];
  int unsigned                stack_cnt = 0;
  rpn_pkg::res_t              expected_q [$];
  int unsigned                err_count = 0;
  int unsigned                idle_run  = 0;

  // evaluate one operation on the shadow stack and return what the block must answer
  function automatic rpn_pkg::res_t eval_op(input rpn_pkg::cmd_t c);
    rpn_pkg::res_t              r;
    logic [rpn_pkg::DATA_W-1:0] lhs;
    logic [rpn_pkg::DATA_W-1:0] rhs;
    logic [rpn_pkg::DATA_W-1:0] val;
    logic [rpn_pkg::DATA_W-1:0] lmag;
    logic [rpn_pkg::DATA_W-1:0] rmag;
    logic [rpn_pkg::DATA_W-1:0] quo;
    r.status  = rpn_pkg::ST_OK;
    r.printed = 1'b0;
    r.result  = '0;
    case (c.op)
      rpn_pkg::OP_PUSH: begin
        if (stack_cnt >= STACK_DEPTH) begin
          r.status = rpn_pkg::ST_OVER;
        end else begin
          stack_mem[stack_cnt] = c.value;
          stack_cnt++;
        end
      end
      rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV: begin
        if (stack_cnt < 2) begin
          r.status = rpn_pkg::ST_UNDER;
        end else begin
          rhs = stack_mem[stack_cnt - 1];
          lhs = stack_mem[stack_cnt - 2];
          if (c.op == rpn_pkg::OP_DIV && rhs == '0) begin
            // both operands stay put
            r.status = rpn_pkg::ST_DIVZ;
          end else begin
            case (c.op)
              rpn_pkg::OP_ADD: val = lhs + rhs;
              rpn_pkg::OP_SUB: val = lhs - rhs;
              rpn_pkg::OP_MUL: val = lhs * rhs;
              default: begin
                // truncate toward zero on magnitudes, most negative / -1 wraps
                lmag = lhs[rpn_pkg::DATA_W-1] ? -lhs : lhs;
                rmag = rhs[rpn_pkg::DATA_W-1] ? -rhs : rhs;
                quo  = lmag / rmag;
                val  = (lhs[rpn_pkg::DATA_W-1] ^ rhs[rpn_pkg::DATA_W-1]) ? -quo : quo;
              end
            endcase
            stack_cnt--;
            stack_mem[stack_cnt - 1] = val;
          end
        end
      end
      rpn_pkg::OP_PRINT: begin
        if (stack_cnt == 0) begin
          r.status = rpn_pkg::ST_UNDER;
        end else begin
          stack_cnt--;
          r.result  = stack_mem[stack_cnt];
          r.printed = 1'b1;
        end
      end
      default: ;  // unused codes leave the stack alone
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %0s: got %h expected %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // drive one item, idling at random first, and hold it until the block takes it
  task automatic send_cmd(input logic [2:0] op, input logic [rpn_pkg::DATA_W-1:0] value,
                          input int unsigned idle_pct);
    rpn_pkg::cmd_t c;
    c.op    = op;
    c.value = value;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      cmd_i   <= rpn_pkg::cmd_t'({3'($urandom_range(7)), $urandom()});
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i   <= c;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_q.push_back(eval_op(c));
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain_results();
    start_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [rpn_pkg::DATA_W-1:0] rand_operand();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 4) return 32'h8000_0000;
    if (pick < 8) return 32'h7fff_ffff;
    if (pick < 12) return 32'hffff_ffff;
    if (pick < 20) return '0;
    if (pick < 45) return 32'($signed($urandom_range(40)) - 20);
    return $urandom();
  endfunction

  function automatic logic [2:0] rand_arith();
    return 3'($urandom_range(rpn_pkg::OP_DIV, rpn_pkg::OP_ADD));
  endfunction

  task automatic test_directed(input int unsigned idle_pct);
    send_cmd(rpn_pkg::OP_PRINT, 32'h1234_5678, idle_pct);  // print with nothing stacked
    send_cmd(rpn_pkg::OP_ADD,   32'hffff_ffff, idle_pct);  // operator on empty stack
    send_cmd(rpn_pkg::OP_PUSH,  32'h7fff_ffff, idle_pct);
    send_cmd(rpn_pkg::OP_SUB,   32'h0,         idle_pct);  // operator with one entry
    send_cmd(rpn_pkg::OP_PUSH,  32'h1,         idle_pct);
    send_cmd(rpn_pkg::OP_ADD,   32'h0,         idle_pct);  // wraps to most negative
    send_cmd(rpn_pkg::OP_PUSH,  32'hffff_ffff, idle_pct);
    send_cmd(rpn_pkg::OP_DIV,   32'h0,         idle_pct);  // most negative / -1
    send_cmd(rpn_pkg::OP_PUSH,  32'h0,         idle_pct);
    send_cmd(rpn_pkg::OP_DIV,   32'h0,         idle_pct);  // divide by zero keeps both
    send_cmd(rpn_pkg::OP_PRINT, 32'h0,         idle_pct);
    send_cmd(rpn_pkg::OP_PUSH,  32'h3,         idle_pct);
    send_cmd(rpn_pkg::OP_MUL,   32'h0,         idle_pct);  // product overflows and wraps
    send_cmd(rpn_pkg::OP_PUSH,  32'hffff_fff9, idle_pct);
    send_cmd(rpn_pkg::OP_PUSH,  32'h2,         idle_pct);
    send_cmd(rpn_pkg::OP_DIV,   32'h0,         idle_pct);  // -7 / 2 rounds toward zero
    send_cmd(rpn_pkg::OP_SUB,   32'h0,         idle_pct);
    send_cmd(OP_SPARE_A,        32'hffff_ffff, idle_pct);  // unused codes are no-ops
    send_cmd(OP_SPARE_B,        32'h8000_0000, idle_pct);
    send_cmd(rpn_pkg::OP_PUSH,  32'h7,         idle_pct);
    send_cmd(rpn_pkg::OP_PUSH,  32'hffff_fffe, idle_pct);
    send_cmd(rpn_pkg::OP_DIV,   32'h0,         idle_pct);  // 7 / -2
    send_cmd(rpn_pkg::OP_SUB,   32'h0,         idle_pct);
    send_cmd(rpn_pkg::OP_PRINT, 32'h0,         idle_pct);
  endtask

  task automatic test_overflow(input int unsigned idle_pct);
    while (stack_cnt < STACK_DEPTH) send_cmd(rpn_pkg::OP_PUSH, rand_operand(), idle_pct);
    send_cmd(rpn_pkg::OP_PUSH, 32'h8000_0000, idle_pct);  // push onto full stack
    send_cmd(rpn_pkg::OP_PRINT, 32'h0, idle_pct);
    send_cmd(rpn_pkg::OP_PUSH, 32'h7fff_ffff, idle_pct);
    send_cmd(rpn_pkg::OP_PUSH, 32'hffff_ffff, idle_pct);
    while (stack_cnt > 1) send_cmd(rand_arith(), $urandom(), idle_pct);
    send_cmd(rpn_pkg::OP_PRINT, 32'h0, idle_pct);
  endtask

  // mostly well-formed expressions, steered by the stack depth, with some noise
  task automatic test_random(input int unsigned n_items, input int unsigned idle_pct);
    int unsigned roll;
    logic [2:0]  op;
    for (int unsigned i = 0; i < n_items; i++) begin
      roll = $urandom_range(99);
      if (roll < 8)
        op = 3'($urandom_range(7));
      else if (stack_cnt < 2)
        op = (roll < 80) ? rpn_pkg::OP_PUSH : rpn_pkg::OP_PRINT;
      else if (stack_cnt >= STACK_DEPTH - 1)
        op = (roll < 30) ? rpn_pkg::OP_PUSH : (roll < 85) ? rand_arith() : rpn_pkg::OP_PRINT;
      else
        op = (roll < 50) ? rpn_pkg::OP_PUSH : (roll < 88) ? rand_arith() : rpn_pkg::OP_PRINT;
      send_cmd(op, (op == rpn_pkg::OP_PUSH) ? rand_operand() : $urandom(), idle_pct);
      if ($urandom_range(199) == 0) drain_results();
    end
  endtask

  // take each result at the edge that ends its strobe cycle and compare it
  always @(posedge clk_i) begin : result_check
    rpn_pkg::res_t want;
    if (rst_ni) begin
      if ($isunknown(done_o)) report_mismatch("done strobe unknown", 32'(done_o), 32'h0);
      if (done_o === 1'b1) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing outstanding", res_o.result, 32'h0);
        end else begin
          want = expected_q.pop_front();
          if (res_o.status !== want.status)
            report_mismatch("status", 32'(res_o.status), 32'(want.status));
          if (res_o.printed !== want.printed)
            report_mismatch("printed", 32'(res_o.printed), 32'(want.printed));
          if (res_o.result !== want.result)
            report_mismatch("result", res_o.result, want.result);
        end
      end
      if ((start_i && !busy_o) || done_o === 1'b1) idle_run = 0;
      else idle_run++;
      if (idle_run >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed(29);
    test_overflow(29);
    test_random(300, 29);
    drain_results();
    test_random(300, 80);
    drain_results();
    test_random(330, 0);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0 && expected_q.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
